### rtl/core/ppb_pkg.sv
package ppb_pkg;

    // Frame dimensions after reset
    localparam int MAX_WIDTH_DEFAULT  = 256;
    localparam int MAX_HEIGHT_DEFAULT = 256;
    localparam logic [8:0] FRAME_DIM_RESET = 9'd256;

    // Config port shape
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // Address field wide enough for the largest supported frame (4096 x 4096)
    localparam int ADDR_MAX_W = 24;

    // Front-to-back command queue
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_OPAQUE = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_OVER   = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_CALC,
        BK_WRITE
    } t_back_state;

    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic [7:0]         src_red;
        logic [7:0]         src_green;
        logic [7:0]         src_blue;
        logic [7:0]         src_alpha;
        logic               straight_alpha;
        logic [1:0]         mode;
    } t_in_item;

    typedef struct packed {
        logic       written;
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_alpha;
    } t_out_item;

    // Stored pixel word: blue in the low byte, alpha in the high byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    // Classified item handed from front to back; colour already premultiplied
    typedef struct packed {
        logic                  in_frame;
        logic [ADDR_MAX_W-1:0] addr;
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic [7:0]            alpha;
        logic [1:0]            mode;
    } t_cmd;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    // floor(v / 255) for v below 65280
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'd1 + 17'(v[15:8]);
        return t[15:8];
    endfunction

    // round(a * b / 255), ties cannot occur
    function automatic logic [7:0] mul_div255(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] p;
        p = 16'(16'(a) * 16'(b)) + 16'd127;
        return div255(p);
    endfunction

endpackage

### rtl/core/ppb_queue.sv
module ppb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ppb_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output ppb_pkg::t_cmd o_data,
    output logic          o_empty
);

    localparam int DEPTH = ppb_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ppb_pkg::t_cmd    r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/core/ppb_front.sv
module ppb_front #(
    parameter int MAX_WIDTH  = ppb_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = ppb_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ppb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ppb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_push,
    input  ppb_pkg::t_in_item              i_in_item,
    output logic                           o_full,
    output logic                           o_q_push,
    output ppb_pkg::t_cmd                  o_q_data,
    input  logic                           i_q_full,
    input  ppb_pkg::t_back_stat            i_back_stat
);

    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [ppb_pkg::CFG_DATA_W-1:0] r_frame_width, r_frame_height;
    logic [16:0] w_lim, h_lim;
    logic        x_ok, y_ok;
    logic [XW-1:0] x_part;
    logic [YW-1:0] y_part;
    logic [31:0]   addr_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= ppb_pkg::FRAME_DIM_RESET;
            r_frame_height <= ppb_pkg::FRAME_DIM_RESET;
        end else if (i_cfg_we) begin
            case (ppb_pkg::t_cfg_idx'(i_cfg_idx))
                ppb_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                ppb_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // zero reads as 1, oversize saturates to the store's limit
    always_comb begin
        w_lim = 17'(r_frame_width);
        if (w_lim == '0) begin
            w_lim = 17'd1;
        end else if (w_lim > 17'(MAX_WIDTH)) begin
            w_lim = 17'(MAX_WIDTH);
        end
        h_lim = 17'(r_frame_height);
        if (h_lim == '0) begin
            h_lim = 17'd1;
        end else if (h_lim > 17'(MAX_HEIGHT)) begin
            h_lim = 17'(MAX_HEIGHT);
        end
    end

    assign x_ok = !i_in_item.pixel_x[15] && ({1'b0, i_in_item.pixel_x} < w_lim);
    assign y_ok = !i_in_item.pixel_y[15] && ({1'b0, i_in_item.pixel_y} < h_lim);

    assign x_part    = i_in_item.pixel_x[XW-1:0];
    assign y_part    = i_in_item.pixel_y[YW-1:0];
    assign addr_full = 32'(y_part) * 32'(MAX_WIDTH) + 32'(x_part);

    always_comb begin
        o_q_data.in_frame = x_ok && y_ok;
        o_q_data.addr     = addr_full[ppb_pkg::ADDR_MAX_W-1:0];
        o_q_data.alpha    = i_in_item.src_alpha;
        o_q_data.mode     = i_in_item.mode;
        if (i_in_item.straight_alpha) begin
            o_q_data.red   = ppb_pkg::mul_div255(i_in_item.src_red,   i_in_item.src_alpha);
            o_q_data.green = ppb_pkg::mul_div255(i_in_item.src_green, i_in_item.src_alpha);
            o_q_data.blue  = ppb_pkg::mul_div255(i_in_item.src_blue,  i_in_item.src_alpha);
        end else begin
            o_q_data.red   = i_in_item.src_red;
            o_q_data.green = i_in_item.src_green;
            o_q_data.blue  = i_in_item.src_blue;
        end
    end

    // no items while the frame store is being cleared
    assign o_full   = i_q_full || i_back_stat.clearing;
    assign o_q_push = i_push && !o_full;

endmodule

### rtl/core/ppb_back.sv
module ppb_back #(
    parameter int MAX_WIDTH  = ppb_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = ppb_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  ppb_pkg::t_cmd       i_q_data,
    output logic                o_q_pop,
    output ppb_pkg::t_back_stat o_stat,
    output logic                o_empty,
    input  logic                i_pop,
    output ppb_pkg::t_out_item  o_out_item
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ppb_pkg::t_back_state r_state, n_state;
    logic [AW-1:0]        r_clr_addr, n_clr_addr;

    logic [31:0]          r_mem [DEPTH];
    logic [31:0]          r_rdata;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr;
    logic [31:0]          mem_wdata;

    ppb_pkg::t_cmd        r_cmd;
    logic [7:0]           r_scaled [4];
    ppb_pkg::t_pixel      dst, src, blend;
    ppb_pkg::t_out_item   r_out, n_out;
    logic                 r_out_valid, out_load, out_free;

    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = 9'(a) + 9'(b);
        return s[8] ? 8'hFF : s[7:0];
    endfunction

    // frame store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[i_q_data.addr[AW-1:0]];
        end
    end

    assign dst = ppb_pkg::t_pixel'(r_rdata);
    always_comb begin
        src.blue  = r_cmd.blue;
        src.green = r_cmd.green;
        src.red   = r_cmd.red;
        src.alpha = r_cmd.alpha;
    end

    // dst scaled by (255 - a); 255 - a is ~a on eight bits
    always_ff @(posedge i_clk) begin
        if (r_state == ppb_pkg::BK_CALC) begin
            r_scaled[0] <= ppb_pkg::mul_div255(dst.blue,  ~r_cmd.alpha);
            r_scaled[1] <= ppb_pkg::mul_div255(dst.green, ~r_cmd.alpha);
            r_scaled[2] <= ppb_pkg::mul_div255(dst.red,   ~r_cmd.alpha);
            r_scaled[3] <= ppb_pkg::mul_div255(dst.alpha, ~r_cmd.alpha);
        end
    end

    always_comb begin
        case (ppb_pkg::t_mode'(r_cmd.mode))
            ppb_pkg::MODE_OPAQUE: begin
                blend       = src;
                blend.alpha = 8'hFF;
            end
            ppb_pkg::MODE_ADD: begin
                blend.blue  = sat_add(src.blue,  dst.blue);
                blend.green = sat_add(src.green, dst.green);
                blend.red   = sat_add(src.red,   dst.red);
                blend.alpha = sat_add(src.alpha, dst.alpha);
            end
            default: begin
                // source-over; unused mode code lands here too
                blend.blue  = sat_add(src.blue,  r_scaled[0]);
                blend.green = sat_add(src.green, r_scaled[1]);
                blend.red   = sat_add(src.red,   r_scaled[2]);
                blend.alpha = sat_add(src.alpha, r_scaled[3]);
            end
        endcase
    end

    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        o_q_pop    = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = r_cmd.addr[AW-1:0];
        mem_wdata  = 32'(blend);
        out_load   = 1'b0;
        n_out.written   = 1'b1;
        n_out.out_blue  = blend.blue;
        n_out.out_green = blend.green;
        n_out.out_red   = blend.red;
        n_out.out_alpha = blend.alpha;
        case (r_state)
            ppb_pkg::BK_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ppb_pkg::BK_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ppb_pkg::BK_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_q_pop = 1'b1;
                    if (i_q_data.in_frame) begin
                        mem_re  = 1'b1;
                        n_state = ppb_pkg::BK_CALC;
                    end else begin
                        out_load = 1'b1;
                        n_out    = '0;
                    end
                end
            end
            ppb_pkg::BK_CALC: begin
                n_state = ppb_pkg::BK_WRITE;
            end
            ppb_pkg::BK_WRITE: begin
                mem_we   = 1'b1;
                out_load = 1'b1;
                n_state  = ppb_pkg::BK_IDLE;
            end
            default: begin
                n_state = ppb_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppb_pkg::BK_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_data;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_stat.clearing = (r_state == ppb_pkg::BK_CLEAR);
    assign o_empty         = !r_out_valid;
    assign o_out_item      = r_out;

`ifndef ASSERT_OFF
    // result register stays free from the pop until write-back
    a_write_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppb_pkg::BK_WRITE) |-> !r_out_valid)
        else $error("result register busy at write-back");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppb_pkg::BK_CLEAR) |-> (!r_out_valid && !o_q_pop))
        else $error("item handled during frame store clear");

    a_rmw_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_data.in_frame) |=>
            (r_state == ppb_pkg::BK_CALC) ##1 (r_state == ppb_pkg::BK_WRITE))
        else $error("read-modify-write sequence broken");

    a_dropped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.written) |->
            (r_out.out_blue == 8'd0 && r_out.out_green == 8'd0 &&
             r_out.out_red == 8'd0 && r_out.out_alpha == 8'd0))
        else $error("dropped item carries colour");
`endif

endmodule

### rtl/core/premultiplied_pixel_blender.sv
// Flow: an accepted item enters the command queue; the back pops it, reads the frame
//   store, scales in BK_CALC and writes back and loads the result in BK_WRITE; an item
//   outside the frame skips the store and loads a zeroed result at the pop. The back
//   takes a new item only in BK_IDLE while its result register is free.
// Reset: synchronous, active low; a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT words
//   (65536 by default) of the frame store with full high; config writes still land.
module premultiplied_pixel_blender #(
    parameter int MAX_WIDTH  = ppb_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = ppb_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item input, queue style
    input  logic                           push,
    input  ppb_pkg::t_in_item              i_in_item,
    output logic                           full,
    // result output, queue style
    output logic                           empty,
    input  logic                           pop,
    output ppb_pkg::t_out_item             o_out_item,
    // config writes
    input  logic                           i_cfg_we,
    input  logic [ppb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ppb_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    // front: bounds check, premultiply and address; back: read-modify-write
    // of the frame store. The queue in between lets the front keep taking
    // items while the back is busy or its result is not yet taken.
    logic                q_push, q_full, q_pop, q_empty;
    ppb_pkg::t_cmd       q_wdata, q_rdata;
    ppb_pkg::t_back_stat back_stat;

    ppb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_in_item   (i_in_item),
        .o_full      (full),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata),
        .i_q_full    (q_full),
        .i_back_stat (back_stat)
    );

    ppb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    ppb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_data   (q_rdata),
        .o_q_pop    (q_pop),
        .o_stat     (back_stat),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_item (o_out_item)
    );

endmodule
